>>> rtl/nlc_pkg.sv
package nlc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CHECKSUM_ENFORCE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LINE_LENGTH  = 1'd1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam logic [15:0] POS_MAX          = 16'hFFFF;
    localparam logic [15:0] MAX_LINE_DEFAULT = 16'd128;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_STRUCT   = 2'd1,
        ST_BAD_CRC  = 2'd2
    } status_t;

    typedef struct packed {
        logic       crc_ok;
        logic       struct_ok;
        logic [7:0] xor_sum;
        logic       too_long;
    } line_summary_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

>>> rtl/nlc_front.sv
module nlc_front
    import nlc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic [15:0]   max_line_length,
    output logic          push,
    output line_summary_t summary
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] pos_reg, pos_next;
    logic        hi_match_reg, hi_match_next;
    logic        lo_match_reg, lo_match_next;
    logic        dollar_reg, dollar_next;
    logic        comma_dollar_reg, comma_dollar_next;
    logic        bang_reg, bang_next;
    logic        comma_bang_reg, comma_bang_next;
    logic        ended_reg, ended_next;
    logic        live;
    logic        is_newline;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SEARCH;
            xor_reg          <= 8'd0;
            pos_reg          <= 16'd0;
            hi_match_reg     <= 1'b0;
            lo_match_reg     <= 1'b0;
            dollar_reg       <= 1'b0;
            comma_dollar_reg <= 1'b0;
            bang_reg         <= 1'b0;
            comma_bang_reg   <= 1'b0;
            ended_reg        <= 1'b0;
        end
        else if (accept)
        begin
            if (is_newline)
            begin
                phase_reg        <= PH_SEARCH;
                xor_reg          <= 8'd0;
                pos_reg          <= 16'd0;
                hi_match_reg     <= 1'b0;
                lo_match_reg     <= 1'b0;
                dollar_reg       <= 1'b0;
                comma_dollar_reg <= 1'b0;
                bang_reg         <= 1'b0;
                comma_bang_reg   <= 1'b0;
                ended_reg        <= 1'b0;
            end
            else
            begin
                phase_reg        <= phase_next;
                xor_reg          <= xor_next;
                pos_reg          <= pos_next;
                hi_match_reg     <= hi_match_next;
                lo_match_reg     <= lo_match_next;
                dollar_reg       <= dollar_next;
                comma_dollar_reg <= comma_dollar_next;
                bang_reg         <= bang_next;
                comma_bang_reg   <= comma_bang_next;
                ended_reg        <= ended_next;
            end
        end
    end

    always_comb
    begin
        is_newline        = (data_byte == CH_NEWLINE);
        ended_next        = ended_reg || (data_byte == CH_NUL);
        live              = !ended_next;
        phase_next        = phase_reg;
        xor_next          = xor_reg;
        hi_match_next     = hi_match_reg;
        lo_match_next     = lo_match_reg;
        dollar_next       = dollar_reg;
        comma_dollar_next = comma_dollar_reg;
        bang_next         = bang_reg;
        comma_bang_next   = comma_bang_reg;

        unique case (phase_reg)
            PH_HEX_HI:
            begin
                hi_match_next = (data_byte == hex_char(xor_reg[7:4]));
                phase_next    = PH_HEX_LO;
            end
            PH_HEX_LO:
            begin
                lo_match_next = (data_byte == hex_char(xor_reg[3:0]));
                phase_next    = PH_DONE;
            end
            PH_SEARCH:
            begin
                if (live && (pos_reg != 16'd0))
                begin
                    if (data_byte == CH_STAR)
                    begin
                        phase_next = PH_HEX_HI;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ data_byte;
                    end
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (live)
        begin
            if (data_byte == CH_COMMA)
            begin
                comma_dollar_next = comma_dollar_reg || dollar_reg;
                comma_bang_next   = comma_bang_reg || bang_reg;
            end
            else if (data_byte == CH_DOLLAR)
            begin
                dollar_next = 1'b1;
            end
            else if (data_byte == CH_BANG)
            begin
                bang_next = 1'b1;
            end
        end

        pos_next = (pos_reg != POS_MAX) ? pos_reg + 16'd1 : pos_reg;

        push              = accept && is_newline;
        summary.crc_ok    = (phase_next == PH_DONE) && hi_match_next && lo_match_next;
        summary.struct_ok = dollar_next ? comma_dollar_next : (bang_next && comma_bang_next);
        summary.xor_sum   = xor_next;
        summary.too_long  = (pos_reg > max_line_length);
    end

endmodule

>>> rtl/nlc_queue.sv
module nlc_queue
    import nlc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  line_summary_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output line_summary_t head
);

    line_summary_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QCNT_W-1:0]       count_reg;

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

endmodule

>>> rtl/nlc_back.sv
module nlc_back
    import nlc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          checksum_enforce,
    input  logic          q_not_empty,
    input  line_summary_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    status,
    output logic          checksum_ok,
    output logic [7:0]    computed_checksum,
    output logic          too_long,
    output logic [31:0]   lines_seen,
    output logic [31:0]   bad_checksums_seen
);

    logic                   valid_reg;
    logic [COUNT_WIDTH-1:0] lines_reg, lines_next;
    logic [COUNT_WIDTH-1:0] bad_reg, bad_next;
    status_t                status_reg, status_next;
    logic                   crc_ok_reg;
    logic [7:0]             xor_reg;
    logic                   long_reg;

    always_comb
    begin
        q_pop      = q_not_empty && (!valid_reg || !out_stall);
        lines_next = lines_reg + 1'b1;
        bad_next   = q_head.crc_ok ? bad_reg : bad_reg + 1'b1;
        priority if (!q_head.crc_ok && checksum_enforce)
        begin
            status_next = ST_BAD_CRC;
        end
        else if (q_head.struct_ok)
        begin
            status_next = ST_VALID;
        end
        else
        begin
            status_next = ST_STRUCT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lines_reg <= '0;
            bad_reg   <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                valid_reg <= 1'b1;
                lines_reg <= lines_next;
                bad_reg   <= bad_next;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            crc_ok_reg <= q_head.crc_ok;
            xor_reg    <= q_head.xor_sum;
            long_reg   <= q_head.too_long;
        end
    end

    assign out_valid          = valid_reg;
    assign status             = status_reg;
    assign checksum_ok        = crc_ok_reg;
    assign computed_checksum  = xor_reg;
    assign too_long           = long_reg;
    assign lines_seen         = 32'(lines_reg);
    assign bad_checksums_seen = 32'(bad_reg);

endmodule

>>> rtl/nmea_line_checker.sv
// NMEA line checker.
// Input channel (in_valid, in_stall, data_byte) takes one byte per item;
// a newline byte closes the line. Each closed line gives one result item on
// the output channel (out_valid, out_stall, status, checksum_ok,
// computed_checksum, too_long, lines_seen, bad_checksums_seen).
// Throughput: one byte per cycle, sustained; in_stall rises only when the
// two-entry line queue between the byte front end and the result stage is
// full, which happens only while the receiver holds out_stall.
// Path: on taking the newline the line summary is written into the queue; it is
// then popped into the output register, which raises out_valid.
// Results stay stable while out_stall is high; bytes keep flowing until two
// further newlines are waiting.
// Configuration: cfg_write with cfg_index 0 sets checksum_enforce (bit 0),
// index 1 sets max_line_length; write only while idle.
// Reset clears the line state, queue, counters and output valid, and loads
// checksum_enforce = 1 and max_line_length = 128.
module nmea_line_checker
    import nlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic                   checksum_ok,
    output logic [7:0]             computed_checksum,
    output logic                   too_long,
    output logic [31:0]            lines_seen,
    output logic [31:0]            bad_checksums_seen,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic          enforce_reg;
    logic [15:0]   max_len_reg;
    logic          accept;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_not_empty;
    line_summary_t push_data;
    line_summary_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enforce_reg <= 1'b1;
            max_len_reg <= MAX_LINE_DEFAULT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CHECKSUM_ENFORCE: enforce_reg <= cfg_data[0];
                REG_MAX_LINE_LENGTH:  max_len_reg <= cfg_data[15:0];
                default:              ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    nlc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .max_line_length (max_len_reg),
        .push            (push),
        .summary         (push_data)
    );

    nlc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    nlc_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .checksum_enforce   (enforce_reg),
        .q_not_empty        (q_not_empty),
        .q_head             (q_head),
        .q_pop              (pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .checksum_ok        (checksum_ok),
        .computed_checksum  (computed_checksum),
        .too_long           (too_long),
        .lines_seen         (lines_seen),
        .bad_checksums_seen (bad_checksums_seen)
    );

endmodule
